>>> src/ssq_pkg.sv
// Shared types and codes for the stable sorted priority queue.
package ssq_pkg;

  // Priority field width, fixed by the item format
  localparam int unsigned PRIO_W = 8;

  // Item mode codes
  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [PRIO_W-1:0] prio;
  } cell_cmd_t;

endpackage

>>> src/ssq_cell.sv
// One slot of the sorted chain: compare against the new priority and shift.
module ssq_cell #(
  parameter int unsigned TAG_BITS = 8
) (
  input  logic                      clk,
  input  ssq_pkg::cell_cmd_t        cmd,
  input  logic [TAG_BITS-1:0]       new_tag,
  input  logic                      occ,
  input  logic                      left_le,
  input  logic [ssq_pkg::PRIO_W-1:0] left_prio,
  input  logic [TAG_BITS-1:0]       left_tag,
  input  logic [ssq_pkg::PRIO_W-1:0] right_prio,
  input  logic [TAG_BITS-1:0]       right_tag,
  output logic                      le,
  output logic [ssq_pkg::PRIO_W-1:0] prio,
  output logic [TAG_BITS-1:0]       tag
);

  logic [ssq_pkg::PRIO_W-1:0] prio_r, prio_nxt;
  logic [TAG_BITS-1:0]        tag_r, tag_nxt;

  // Held entry stays ahead of the new one when its value is lower or equal
  assign le = occ && (prio_r <= cmd.prio);

  // Keep, take the new entry, take the left neighbor, or take the right one
  always_comb begin
    prio_nxt = prio_r;
    tag_nxt  = tag_r;
    if (cmd.ins) begin
      if (!le) begin
        if (left_le) begin
          prio_nxt = cmd.prio;
          tag_nxt  = new_tag;
        end else begin
          prio_nxt = left_prio;
          tag_nxt  = left_tag;
        end
      end
    end else if (cmd.rem) begin
      prio_nxt = right_prio;
      tag_nxt  = right_tag;
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    tag_r  <= tag_nxt;
  end

  assign prio = prio_r;
  assign tag  = tag_r;

endmodule

>>> src/stable_sorted_priority_queue.sv
// Top level: chain of compare-and-shift cells, entry counter and result register.
//
//   channel | direction | ports
//   --------+-----------+-------------------------------------------------------
//   in      | input     | in_valid, in_stall, in_mode, in_new_priority, in_job_tag
//   out     | output    | out_valid, out_stall, out_status, out_removed_tag,
//           |           | out_head_valid, out_head_priority, out_head_tag,
//           |           | out_occupancy
//
// Each beat is handled in the cycle it is accepted: every cell compares and
// shifts at once, and the result beat is valid on the next cycle.
// One beat per cycle while the result side takes beats; the single result
// register sets the rate, and in_stall is high while it holds an untaken beat.
// Reset clears the entry count and the result register; slot contents are
// not cleared and no clearing pass is run.
module stable_sorted_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TAG_BITS    = 8,
  localparam int unsigned CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_mode,
  input  logic [ssq_pkg::PRIO_W-1:0] in_new_priority,
  input  logic [TAG_BITS-1:0]        in_job_tag,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic [TAG_BITS-1:0]        out_removed_tag,
  output logic                       out_head_valid,
  output logic [ssq_pkg::PRIO_W-1:0] out_head_priority,
  output logic [TAG_BITS-1:0]        out_head_tag,
  output logic [CNT_W-1:0]           out_occupancy
);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  logic                        accept;
  logic                        full, empty;
  ssq_pkg::cell_cmd_t          cmd;
  ssq_pkg::status_t            status_r, status_nxt;
  logic [TAG_BITS-1:0]         removed_r, removed_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic [QUEUE_DEPTH-1:0]      le;
  logic [ssq_pkg::PRIO_W-1:0]  prio [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]         tag  [QUEUE_DEPTH];

  // Input handshake: one result register parts the two sides
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count_r == DEPTH_C);
  assign empty    = (count_r == '0);

  // Command to the cells and result of this beat
  always_comb begin
    cmd.prio    = in_new_priority;
    cmd.ins     = 1'b0;
    cmd.rem     = 1'b0;
    status_nxt  = status_r;
    removed_nxt = removed_r;
    count_nxt   = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (accept) begin
      out_valid_nxt = 1'b1;
      removed_nxt   = '0;
      status_nxt    = ssq_pkg::ST_DONE;
      if (ssq_pkg::mode_t'(in_mode) == ssq_pkg::MODE_INSERT) begin
        if (full) begin
          status_nxt = ssq_pkg::ST_FULL;
        end else begin
          cmd.ins   = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end else begin
        if (empty) begin
          status_nxt = ssq_pkg::ST_EMPTY;
        end else begin
          cmd.rem     = 1'b1;
          removed_nxt = tag[0];
          count_nxt   = count_r - 1'b1;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      status_r    <= ssq_pkg::ST_DONE;
      removed_r   <= '0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
      removed_r   <= removed_nxt;
    end
  end

  // Chain of cells; slot i is occupied while i is below the count
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                       c_left_le;
    logic [ssq_pkg::PRIO_W-1:0] c_left_prio, c_right_prio;
    logic [TAG_BITS-1:0]        c_left_tag, c_right_tag;

    if (i == 0) begin : g_first
      assign c_left_le   = 1'b1;
      assign c_left_prio = '0;
      assign c_left_tag  = '0;
    end else begin : g_mid
      assign c_left_le   = le[i-1];
      assign c_left_prio = prio[i-1];
      assign c_left_tag  = tag[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign c_right_prio = '0;
      assign c_right_tag  = '0;
    end else begin : g_inner
      assign c_right_prio = prio[i+1];
      assign c_right_tag  = tag[i+1];
    end

    ssq_cell #(
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .new_tag    (in_job_tag),
      .occ        (CNT_W'(i) < count_r),
      .left_le    (c_left_le),
      .left_prio  (c_left_prio),
      .left_tag   (c_left_tag),
      .right_prio (c_right_prio),
      .right_tag  (c_right_tag),
      .le         (le[i]),
      .prio       (prio[i]),
      .tag        (tag[i])
    );
  end

  // Result beat: head read straight from the first cell, which holds while stalled
  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_removed_tag   = removed_r;
  assign out_occupancy     = count_r;
  assign out_head_valid    = !empty;
  assign out_head_priority = empty ? '0 : prio[0];
  assign out_head_tag      = empty ? '0 : tag[0];

endmodule

>>> src/ssq_checker.sv
// Port-level checks for the stable sorted priority queue, bound to the top level.
module ssq_checker #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TAG_BITS    = 8,
  localparam int unsigned CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [1:0]                 out_status,
  input logic [TAG_BITS-1:0]        out_removed_tag,
  input logic                       out_head_valid,
  input logic [ssq_pkg::PRIO_W-1:0] out_head_priority,
  input logic [TAG_BITS-1:0]        out_head_tag,
  input logic [CNT_W-1:0]           out_occupancy
);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_occupancy) && $stable(out_head_tag)
      && $stable(out_head_priority))
    else $error("stalled result beat changed");

  // Head valid tracks occupancy, and the count never passes the depth
  a_head_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_head_valid == (out_occupancy != '0))
      && (out_occupancy <= DEPTH_C))
    else $error("head valid and occupancy disagree");

  // A full rejection reports a full queue, an empty rejection an empty one
  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != ssq_pkg::ST_FULL || out_occupancy == DEPTH_C)
      && (out_status != ssq_pkg::ST_EMPTY
          || (out_occupancy == '0 && out_removed_tag == '0)))
    else $error("rejection status disagrees with occupancy");

  // Each accepted beat changes occupancy by at most one
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && out_valid && !out_stall |=>
      out_valid && (out_occupancy == $past(out_occupancy)
        || out_occupancy == $past(out_occupancy) + 1'b1
        || out_occupancy == $past(out_occupancy) - 1'b1))
    else $error("occupancy jumped by more than one");

endmodule

bind stable_sorted_priority_queue ssq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH),
  .TAG_BITS    (TAG_BITS)
) u_ssq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_removed_tag   (out_removed_tag),
  .out_head_valid    (out_head_valid),
  .out_head_priority (out_head_priority),
  .out_head_tag      (out_head_tag),
  .out_occupancy     (out_occupancy)
);

>>> tb/sv/tb_stable_sorted_priority_queue.sv
// Testbench for the stable sorted priority queue: directed and random beats checked on a model.
`timescale 1ns / 1ps

module tb_stable_sorted_priority_queue;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned TAG_W     = 8;
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned N_RANDOM  = 1750;
  localparam int unsigned LIMIT     = 1000000;
  localparam int unsigned TAIL_WAIT = 16;

  typedef struct {
    ssq_pkg::mode_t             mode;
    logic [ssq_pkg::PRIO_W-1:0] prio;
    logic [TAG_W-1:0]           tag;
    bit                         wait_drain;  // hold this beat until all results are back
  } pq_item_t;

  typedef struct {
    ssq_pkg::status_t           status;
    logic [TAG_W-1:0]           removed_tag;
    logic                       head_valid;
    logic [ssq_pkg::PRIO_W-1:0] head_prio;
    logic [TAG_W-1:0]           head_tag;
    logic [CNT_W-1:0]           occupancy;
  } pq_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_mode = 1'b0;
  logic [ssq_pkg::PRIO_W-1:0] in_new_priority = '0;
  logic [TAG_W-1:0]           in_job_tag = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [1:0]                 out_status;
  logic [TAG_W-1:0]           out_removed_tag;
  logic                       out_head_valid;
  logic [ssq_pkg::PRIO_W-1:0] out_head_priority;
  logic [TAG_W-1:0]           out_head_tag;
  logic [CNT_W-1:0]           out_occupancy;

  pq_item_t   pending_items[$];
  pq_result_t expected_results[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          in_beat_taken = 1'b0;
  int          send_gap = 0;
  int          send_calm = 0;
  int          stall_left = 0;
  int          recv_calm = 0;

  // Model state: sorted row of held entries
  logic [ssq_pkg::PRIO_W-1:0] row_prio[DEPTH];
  logic [TAG_W-1:0]           row_tag[DEPTH];
  int unsigned                held = 0;

  stable_sorted_priority_queue #(
    .QUEUE_DEPTH(DEPTH),
    .TAG_BITS   (TAG_W)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_new_priority  (in_new_priority),
    .in_job_tag       (in_job_tag),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_removed_tag  (out_removed_tag),
    .out_head_valid   (out_head_valid),
    .out_head_priority(out_head_priority),
    .out_head_tag     (out_head_tag),
    .out_occupancy    (out_occupancy)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Applies one beat to the model queue and returns the result it should produce
  function automatic pq_result_t sorted_queue_step(pq_item_t it);
    pq_result_t r;
    int unsigned pos;
    int unsigned k;
    r.status      = ssq_pkg::ST_DONE;
    r.removed_tag = '0;
    if (it.mode == ssq_pkg::MODE_INSERT) begin
      if (held >= DEPTH) begin
        r.status = ssq_pkg::ST_FULL;
      end else begin
        // new entry goes behind every entry of lower or equal value
        pos = 0;
        while (pos < held && row_prio[pos] <= it.prio) pos++;
        for (k = held; k > pos; k--) begin
          row_prio[k] = row_prio[k-1];
          row_tag[k]  = row_tag[k-1];
        end
        row_prio[pos] = it.prio;
        row_tag[pos]  = it.tag;
        held++;
      end
    end else begin
      if (held == 0) begin
        r.status = ssq_pkg::ST_EMPTY;
      end else begin
        r.removed_tag = row_tag[0];
        for (k = 1; k < held; k++) begin
          row_prio[k-1] = row_prio[k];
          row_tag[k-1]  = row_tag[k];
        end
        held--;
      end
    end
    r.head_valid = (held != 0);
    r.head_prio  = (held != 0) ? row_prio[0] : '0;
    r.head_tag   = (held != 0) ? row_tag[0] : '0;
    r.occupancy  = CNT_W'(held);
    return r;
  endfunction

  // Idle length: mostly none or short, a few long, with calm stretches of none
  function automatic int idle_len(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 199);
    if (r < 2) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 110) return 0;
    if (r < 185) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: cycle %0d field %s expected %0d got %0d", cycle_count, name, want, got);
    end
  endtask

  task automatic push_item(ssq_pkg::mode_t mode, int prio, int tag, bit drain);
    pq_item_t it;
    it.mode       = mode;
    it.prio       = ssq_pkg::PRIO_W'(prio);
    it.tag        = TAG_W'(tag);
    it.wait_drain = drain;
    pending_items.push_back(it);
  endtask

  // Input driver: presents beats at the falling edge
  always @(negedge clk) begin
    pq_item_t cur;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_beat_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0 &&
                   !(pending_items[0].wait_drain && expected_results.size() != 0)) begin
        cur = pending_items.pop_front();
        in_mode         <= cur.mode;
        in_new_priority <= cur.prio;
        in_job_tag      <= cur.tag;
        in_valid        <= 1'b1;
        send_gap = idle_len(send_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = idle_len(recv_calm);
    end
  end

  // Monitor: checks result beats, then predicts accepted input beats
  always @(posedge clk) begin
    pq_item_t   it;
    pq_result_t want;
    cycle_count++;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: cycle %0d result beat with nothing expected", cycle_count);
      end else begin
        want = expected_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("removed_tag", 32'(want.removed_tag), 32'(out_removed_tag));
        check_field("head_valid", 32'(want.head_valid), 32'(out_head_valid));
        check_field("head_priority", 32'(want.head_prio), 32'(out_head_priority));
        check_field("head_tag", 32'(want.head_tag), 32'(out_head_tag));
        check_field("occupancy", 32'(want.occupancy), 32'(out_occupancy));
      end
    end
    in_beat_taken = rst_n && in_valid && !in_stall;
    if (in_beat_taken) begin
      it.mode       = ssq_pkg::mode_t'(in_mode);
      it.prio       = in_new_priority;
      it.tag        = in_job_tag;
      it.wait_drain = 1'b0;
      expected_results.push_back(sorted_queue_step(it));
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int n;
    int len;
    int bias;
    int span;
    int base;
    int prio;
    ssq_pkg::mode_t mode;
    bit drain;

    // Directed: empty removes, extremes, ties, fill to full, full insert
    push_item(ssq_pkg::MODE_REMOVE, 8'hFF, 8'hFF, 1'b0);
    push_item(ssq_pkg::MODE_REMOVE, 0, 0, 1'b0);
    push_item(ssq_pkg::MODE_INSERT, 255, 255, 1'b0);
    push_item(ssq_pkg::MODE_INSERT, 255, 8'h55, 1'b0);
    push_item(ssq_pkg::MODE_INSERT, 0, 0, 1'b0);
    push_item(ssq_pkg::MODE_INSERT, 0, 8'hAA, 1'b0);
    push_item(ssq_pkg::MODE_REMOVE, 0, 0, 1'b0);
    for (int i = 0; i < 13; i++)
      push_item(ssq_pkg::MODE_INSERT, (i * 37) % 256, 8'h10 + i, 1'b0);
    push_item(ssq_pkg::MODE_INSERT, 128, 8'hC3, 1'b0);
    push_item(ssq_pkg::MODE_INSERT, 0, 8'h3C, 1'b0);
    push_item(ssq_pkg::MODE_REMOVE, 0, 0, 1'b0);
    push_item(ssq_pkg::MODE_REMOVE, 0, 0, 1'b0);
    push_item(ssq_pkg::MODE_INSERT, 255, 8'hFE, 1'b0);

    // Random episodes: insert-heavy, remove-heavy or mixed, with varied priority spread
    n = 0;
    while (n < N_RANDOM) begin
      bias  = $urandom_range(0, 2);
      span  = $urandom_range(0, 3);
      base  = $urandom_range(0, 248);
      len   = $urandom_range(8, 60);
      drain = (n == 0) || ($urandom_range(0, 9) == 0);
      for (int i = 0; i < len; i++) begin
        case (bias)
          0: mode = ($urandom_range(0, 99) < 80) ? ssq_pkg::MODE_INSERT
                                                 : ssq_pkg::MODE_REMOVE;
          1: mode = ($urandom_range(0, 99) < 20) ? ssq_pkg::MODE_INSERT
                                                 : ssq_pkg::MODE_REMOVE;
          default: mode = ($urandom_range(0, 1) == 0) ? ssq_pkg::MODE_INSERT
                                                      : ssq_pkg::MODE_REMOVE;
        endcase
        case (span)
          0: prio = $urandom_range(0, 255);
          1: prio = $urandom_range(0, 3);
          2: prio = ($urandom_range(0, 1) == 0) ? 0 : 255;
          default: prio = base + $urandom_range(0, 7);
        endcase
        push_item(mode, prio, $urandom_range(0, 255), drain && (i == 0));
        n++;
      end
    end

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Wait for all beats to be sent and all results to come back
    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
